// ----- src/baro_sensor_compensation_macros.svh -----
// Assertion macros shared by the checker of the pressure compensation block.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef BARO_SENSOR_COMPENSATION_MACROS_SVH
`define BARO_SENSOR_COMPENSATION_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BCMP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BCMP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/bcmp_pkg.sv -----
// Shared widths, constants, register codes and payload types of the
// pressure compensation block. Depends on nothing.
package bcmp_pkg;

    localparam int RAW_W    = 24;
    localparam int CAL_W    = 16;
    localparam int TEMP_W   = 21;
    localparam int PRES_W   = 32;

    localparam int APB_DW    = 32;
    localparam int APB_AW    = 5;
    localparam int REG_IDX_W = 3;
    localparam int NUM_REGS  = 6;

    localparam logic [REG_IDX_W-1:0] REG_SENS          = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_OFFSET        = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SENS_TEMPCO   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_OFFSET_TEMPCO = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_REF_TEMP      = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_TEMP_COEFF    = 3'd5;

    localparam logic [APB_DW-1:0] CAL_MASK = APB_DW'({CAL_W{1'b1}});

    localparam int REF_TEMP_SHIFT  = 8;
    localparam int OFF_BASE_SHIFT  = 17;
    localparam int SENS_BASE_SHIFT = 16;
    localparam int TEMP_SHIFT      = 23;
    localparam int OFF_SHIFT       = 6;
    localparam int SENS_SHIFT      = 7;
    localparam int T2_SHIFT        = 31;
    localparam int OFF2_MUL        = 61;
    localparam int OFF2_SHIFT      = 4;
    localparam int VLOW_OFF_MUL    = 15;
    localparam int VLOW_SENS_SHIFT = 3;
    localparam int PRES_SHIFT1     = 21;
    localparam int PRES_SHIFT2     = 15;

    localparam int TEMP_REF  = 2000;
    localparam int VLOW_TEMP = -1500;

    localparam int DT_W     = RAW_W + 1;
    localparam int PT_W     = DT_W + CAL_W + 1;
    localparam int PDD_W    = 2 * DT_W;
    localparam int M_W      = PT_W - TEMP_SHIFT;
    localparam int SQ_W     = 2 * M_W;
    localparam int T2_W     = 17;
    localparam int OFF_W    = 42;
    localparam int SENS_W   = 40;
    localparam int OFF2_W   = 40;
    localparam int SENS2_W  = 39;
    localparam int SPLIT_W  = 20;
    localparam int PLO_W    = RAW_W + SPLIT_W;
    localparam int PHI_W    = RAW_W + 1 + SENS_W - SPLIT_W;
    localparam int PROD_W   = 64;
    localparam int DIFF_W   = PROD_W - PRES_SHIFT1 + 1;

    typedef struct packed {
        logic [CAL_W-1:0] sens;
        logic [CAL_W-1:0] offset;
        logic [CAL_W-1:0] sens_tempco;
        logic [CAL_W-1:0] offset_tempco;
        logic [CAL_W-1:0] ref_temp;
        logic [CAL_W-1:0] temp_coeff;
    } cal_t;

    typedef struct packed {
        logic [RAW_W-1:0]         d1;
        logic signed [TEMP_W-1:0] temp;
        logic signed [M_W-1:0]    m;
        logic signed [M_W-1:0]    q;
        logic [T2_W-1:0]          t2;
        logic signed [OFF_W-1:0]  off;
        logic signed [SENS_W-1:0] sens;
    } front_t;

    typedef struct packed {
        logic [RAW_W-1:0]         d1;
        logic signed [TEMP_W-1:0] temp;
        logic signed [OFF_W-1:0]  off;
        logic signed [SENS_W-1:0] sens;
    } corr_t;

endpackage

// ----- src/bcmp_if.sv -----
// Valid/ready channel interfaces for raw conversions and compensated results.
// Depends on bcmp_pkg for the field widths.
interface bcmp_raw_if import bcmp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [RAW_W-1:0] raw_pressure;
    logic [RAW_W-1:0] raw_temperature;

    modport source (output valid, output raw_pressure, output raw_temperature, input ready);
    modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

interface bcmp_comp_if import bcmp_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [TEMP_W-1:0] temperature_centi;
    logic signed [PRES_W-1:0] pressure_pa;

    modport source (output valid, output temperature_centi, output pressure_pa, input ready);
    modport sink   (input valid, input temperature_centi, input pressure_pa, output ready);
endinterface

// ----- src/baro_sensor_compensation.sv -----
// Top level of the barometric pressure compensation pipeline.
// An accepted raw transaction passes through nine pipeline stages to its result.
// Throughput is one transaction per cycle while the output is not stalled; each stage
// holds its item while stalled, and empty stages keep accepting while a result waits.
// Reset clears all valid bits and sets the six calibration words to zero.
module baro_sensor_compensation import bcmp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    bcmp_raw_if.sink          raw,
    bcmp_comp_if.source       comp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    cal_t   cal;
    logic   front_valid;
    logic   front_ready;
    front_t front_data;
    logic   corr_valid;
    logic   corr_ready;
    corr_t  corr_data;

    bcmp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cal     (cal)
    );

    bcmp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cal      (cal),
        .raw      (raw),
        .dn_valid (front_valid),
        .dn_ready (front_ready),
        .dn_data  (front_data)
    );

    bcmp_corr u_corr (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (front_valid),
        .up_ready (front_ready),
        .up_data  (front_data),
        .dn_valid (corr_valid),
        .dn_ready (corr_ready),
        .dn_data  (corr_data)
    );

    bcmp_press u_press (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (corr_valid),
        .up_ready (corr_ready),
        .up_data  (corr_data),
        .comp     (comp)
    );

endmodule

// ----- src/bcmp_regs.sv -----
// APB register file that holds the six calibration words.
// Depends on bcmp_pkg for the register codes and the cal_t type.
module bcmp_regs import bcmp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cal_t              cal
);

    logic [REG_IDX_W-1:0] idx;
    logic                 wr_en;
    cal_t                 cal_reg;
    cal_t                 cal_next;

    assign pready = 1'b1;
    assign idx    = paddr[APB_AW-1:2];
    assign wr_en  = psel && penable && pwrite && pready;
    assign cal    = cal_reg;

    always_comb
    begin
        cal_next = cal_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_SENS:          cal_next.sens          = pwdata[CAL_W-1:0];
                REG_OFFSET:        cal_next.offset        = pwdata[CAL_W-1:0];
                REG_SENS_TEMPCO:   cal_next.sens_tempco   = pwdata[CAL_W-1:0];
                REG_OFFSET_TEMPCO: cal_next.offset_tempco = pwdata[CAL_W-1:0];
                REG_REF_TEMP:      cal_next.ref_temp      = pwdata[CAL_W-1:0];
                REG_TEMP_COEFF:    cal_next.temp_coeff    = pwdata[CAL_W-1:0];
                default:           cal_next = cal_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg <= '0;
        end
        else
        begin
            cal_reg <= cal_next;
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_SENS:          prdata = APB_DW'(cal_reg.sens);
            REG_OFFSET:        prdata = APB_DW'(cal_reg.offset);
            REG_SENS_TEMPCO:   prdata = APB_DW'(cal_reg.sens_tempco);
            REG_OFFSET_TEMPCO: prdata = APB_DW'(cal_reg.offset_tempco);
            REG_REF_TEMP:      prdata = APB_DW'(cal_reg.ref_temp);
            REG_TEMP_COEFF:    prdata = APB_DW'(cal_reg.temp_coeff);
            default:           prdata = '0;
        endcase
    end

endmodule

// ----- src/bcmp_front.sv -----
// First-order stages: temperature difference, the four calibration products,
// then TEMP, OFF, SENS and the second-order operands. Depends on bcmp_pkg and bcmp_if.
module bcmp_front import bcmp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cal_t       cal,
    bcmp_raw_if.sink   raw,
    output logic       dn_valid,
    input  logic       dn_ready,
    output front_t     dn_data
);

    localparam int NS = 3;

    logic [NS-1:0] valid_reg;
    logic [NS-1:0] valid_next;
    logic [NS:0]   adv;

    logic [RAW_W-1:0]        d1_s0_reg;
    logic signed [DT_W-1:0]  dt_reg;
    logic signed [DT_W-1:0]  dt_next;
    logic [RAW_W-1:0]        d1_s1_reg;
    logic signed [PT_W-1:0]  pt_reg;
    logic signed [PT_W-1:0]  pt_next;
    logic signed [PT_W-1:0]  po_reg;
    logic signed [PT_W-1:0]  po_next;
    logic signed [PT_W-1:0]  ps_reg;
    logic signed [PT_W-1:0]  ps_next;
    logic signed [PDD_W-1:0] pdd_reg;
    logic signed [PDD_W-1:0] pdd_next;
    logic signed [M_W-1:0]   m;
    front_t                  out_reg;
    front_t                  out_next;

    always_comb
    begin
        adv[NS] = dn_ready;
        for (int k = NS - 1; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
        valid_next = valid_reg;
        if (adv[0])
        begin
            valid_next[0] = raw.valid;
        end
        for (int k = 1; k < NS; k++)
        begin
            if (adv[k])
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign raw.ready = adv[0];
    assign dn_valid  = valid_reg[NS-1];
    assign dn_data   = out_reg;

    always_comb
    begin
        dt_next = $signed({1'b0, raw.raw_temperature})
                - $signed({1'b0, cal.ref_temp, {REF_TEMP_SHIFT{1'b0}}});

        pt_next  = PT_W'(dt_reg) * PT_W'($signed({1'b0, cal.temp_coeff}));
        po_next  = PT_W'(dt_reg) * PT_W'($signed({1'b0, cal.offset_tempco}));
        ps_next  = PT_W'(dt_reg) * PT_W'($signed({1'b0, cal.sens_tempco}));
        pdd_next = PDD_W'(dt_reg) * PDD_W'(dt_reg);

        m             = $signed(pt_reg[PT_W-1:TEMP_SHIFT]);
        out_next.d1   = d1_s1_reg;
        out_next.m    = m;
        out_next.q    = m + M_W'(TEMP_REF - VLOW_TEMP);
        out_next.temp = TEMP_W'(m) + TEMP_W'(TEMP_REF);
        out_next.t2   = pdd_reg[T2_SHIFT+T2_W-1:T2_SHIFT];
        out_next.off  = OFF_W'($signed({1'b0, cal.offset, {OFF_BASE_SHIFT{1'b0}}}))
                      + OFF_W'($signed(po_reg[PT_W-1:OFF_SHIFT]));
        out_next.sens = SENS_W'($signed({1'b0, cal.sens, {SENS_BASE_SHIFT{1'b0}}}))
                      + SENS_W'($signed(ps_reg[PT_W-1:SENS_SHIFT]));
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            d1_s0_reg <= raw.raw_pressure;
            dt_reg    <= dt_next;
        end
        if (adv[1])
        begin
            d1_s1_reg <= d1_s0_reg;
            pt_reg    <= pt_next;
            po_reg    <= po_next;
            ps_reg    <= ps_next;
            pdd_reg   <= pdd_next;
        end
        if (adv[2])
        begin
            out_reg <= out_next;
        end
    end

endmodule

// ----- src/bcmp_corr.sv -----
// Second-order low-temperature correction stages: squares and corrected TEMP,
// correction terms, then corrected OFF and SENS. Depends on bcmp_pkg.
module bcmp_corr import bcmp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   up_valid,
    output logic   up_ready,
    input  front_t up_data,
    output logic   dn_valid,
    input  logic   dn_ready,
    output corr_t  dn_data
);

    localparam int NS = 3;

    logic [NS-1:0] valid_reg;
    logic [NS-1:0] valid_next;
    logic [NS:0]   adv;

    logic [SQ_W-1:0]          mm_reg;
    logic [SQ_W-1:0]          mm_next;
    logic [SQ_W-1:0]          qq_reg;
    logic [SQ_W-1:0]          qq_next;
    logic                     low_reg;
    logic                     vlow_reg;
    logic signed [TEMP_W-1:0] temp_next;
    corr_t                    s0_reg;
    logic [OFF2_W-1:0]        off2_reg;
    logic [OFF2_W-1:0]        off2_next;
    logic [SENS2_W-1:0]       sens2_reg;
    logic [SENS2_W-1:0]       sens2_next;
    corr_t                    s1_reg;
    corr_t                    out_reg;
    corr_t                    out_next;

    always_comb
    begin
        adv[NS] = dn_ready;
        for (int k = NS - 1; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
        valid_next = valid_reg;
        if (adv[0])
        begin
            valid_next[0] = up_valid;
        end
        for (int k = 1; k < NS; k++)
        begin
            if (adv[k])
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign up_ready = adv[0];
    assign dn_valid = valid_reg[NS-1];
    assign dn_data  = out_reg;

    always_comb
    begin
        mm_next = SQ_W'(SQ_W'(up_data.m) * SQ_W'(up_data.m));
        qq_next = SQ_W'(SQ_W'(up_data.q) * SQ_W'(up_data.q));
        if (up_data.m[M_W-1])
        begin
            temp_next = up_data.temp - $signed(TEMP_W'(up_data.t2));
        end
        else
        begin
            temp_next = up_data.temp;
        end

        off2_next  = '0;
        sens2_next = '0;
        if (low_reg)
        begin
            off2_next  = (OFF2_W'(mm_reg) * OFF2_W'(OFF2_MUL)) >> OFF2_SHIFT;
            sens2_next = SENS2_W'(mm_reg) << 1;
            if (vlow_reg)
            begin
                off2_next  = off2_next + OFF2_W'(qq_reg) * OFF2_W'(VLOW_OFF_MUL);
                sens2_next = sens2_next + (SENS2_W'(qq_reg) << VLOW_SENS_SHIFT);
            end
        end

        out_next.d1   = s1_reg.d1;
        out_next.temp = s1_reg.temp;
        out_next.off  = s1_reg.off - $signed(OFF_W'(off2_reg));
        out_next.sens = s1_reg.sens - $signed(SENS_W'(sens2_reg));
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            mm_reg      <= mm_next;
            qq_reg      <= qq_next;
            low_reg     <= up_data.m[M_W-1];
            vlow_reg    <= up_data.q[M_W-1];
            s0_reg.d1   <= up_data.d1;
            s0_reg.temp <= temp_next;
            s0_reg.off  <= up_data.off;
            s0_reg.sens <= up_data.sens;
        end
        if (adv[1])
        begin
            off2_reg  <= off2_next;
            sens2_reg <= sens2_next;
            s1_reg    <= s0_reg;
        end
        if (adv[2])
        begin
            out_reg <= out_next;
        end
    end

endmodule

// ----- src/bcmp_press.sv -----
// Pressure stages: split product D1*SENS, partial product sum, final scaling,
// and the result register. Depends on bcmp_pkg and bcmp_if.
module bcmp_press import bcmp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      up_valid,
    output logic      up_ready,
    input  corr_t     up_data,
    bcmp_comp_if.source comp
);

    localparam int NS = 3;

    logic [NS-1:0] valid_reg;
    logic [NS-1:0] valid_next;
    logic [NS:0]   adv;

    logic [PLO_W-1:0]         plo_reg;
    logic [PLO_W-1:0]         plo_next;
    logic signed [PHI_W-1:0]  phi_reg;
    logic signed [PHI_W-1:0]  phi_next;
    logic signed [OFF_W-1:0]  off_s0_reg;
    logic signed [TEMP_W-1:0] temp_s0_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [OFF_W-1:0]  off_s1_reg;
    logic signed [TEMP_W-1:0] temp_s1_reg;
    logic signed [DIFF_W-1:0] diff;
    logic signed [TEMP_W-1:0] temp_reg;
    logic signed [PRES_W-1:0] pres_reg;
    logic signed [PRES_W-1:0] pres_next;

    always_comb
    begin
        adv[NS] = comp.ready;
        for (int k = NS - 1; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
        valid_next = valid_reg;
        if (adv[0])
        begin
            valid_next[0] = up_valid;
        end
        for (int k = 1; k < NS; k++)
        begin
            if (adv[k])
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign up_ready               = adv[0];
    assign comp.valid             = valid_reg[NS-1];
    assign comp.temperature_centi = temp_reg;
    assign comp.pressure_pa       = pres_reg;

    always_comb
    begin
        plo_next  = PLO_W'(up_data.d1) * PLO_W'(up_data.sens[SPLIT_W-1:0]);
        phi_next  = PHI_W'($signed({1'b0, up_data.d1}))
                  * PHI_W'($signed(up_data.sens[SENS_W-1:SPLIT_W]));
        prod_next = (PROD_W'(phi_reg) <<< SPLIT_W) + $signed(PROD_W'(plo_reg));
        diff      = DIFF_W'(prod_reg >>> PRES_SHIFT1) - DIFF_W'(off_s1_reg);
        pres_next = PRES_W'(diff >>> PRES_SHIFT2);
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            plo_reg     <= plo_next;
            phi_reg     <= phi_next;
            off_s0_reg  <= up_data.off;
            temp_s0_reg <= up_data.temp;
        end
        if (adv[1])
        begin
            prod_reg    <= prod_next;
            off_s1_reg  <= off_s0_reg;
            temp_s1_reg <= temp_s0_reg;
        end
        if (adv[2])
        begin
            temp_reg <= temp_s1_reg;
            pres_reg <= pres_next;
        end
    end

endmodule

// ----- src/bcmp_checker.sv -----
// Port-level checker for the pressure compensation block, bound to the top level.
// Depends on bcmp_pkg and the assertion macros header.
`include "baro_sensor_compensation_macros.svh"

module bcmp_checker import bcmp_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     raw_ready,
    input logic                     comp_valid,
    input logic                     comp_ready,
    input logic signed [TEMP_W-1:0] comp_temperature_centi,
    input logic signed [PRES_W-1:0] comp_pressure_pa,
    input logic                     psel,
    input logic                     penable,
    input logic                     pwrite,
    input logic                     pready,
    input logic [APB_AW-1:0]        paddr,
    input logic [APB_DW-1:0]        pwdata,
    input logic [APB_DW-1:0]        prdata
);

    // An open output slot must let every stage move, so the input side is ready.
    `BCMP_ASSERT_SAME(a_ready_chain, !comp_valid || comp_ready, raw_ready, "input not ready with output free")

    `BCMP_ASSERT_SAME(a_reset_empty, $rose(rst_n), !comp_valid, "result valid right after reset")

    `BCMP_ASSERT_NEXT(a_cfg_readback, psel && penable && pwrite && pready && (paddr[APB_AW-1:2] < REG_IDX_W'(NUM_REGS)), (paddr != $past(paddr)) || (prdata == ($past(pwdata) & CAL_MASK)), "calibration word readback mismatch")

    `BCMP_ASSERT_NEXT(a_result_hold, comp_valid && !comp_ready, comp_valid && $stable(comp_temperature_centi) && $stable(comp_pressure_pa), "stalled result changed")

endmodule

bind baro_sensor_compensation bcmp_checker u_bcmp_checker (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .raw_ready              (raw.ready),
    .comp_valid             (comp.valid),
    .comp_ready             (comp.ready),
    .comp_temperature_centi (comp.temperature_centi),
    .comp_pressure_pa       (comp.pressure_pa),
    .psel                   (psel),
    .penable                (penable),
    .pwrite                 (pwrite),
    .pready                 (pready),
    .paddr                  (paddr),
    .pwdata                 (pwdata),
    .prdata                 (prdata)
);
